FILE: rtl/bac_pkg.sv
// shared constants, types and the root table for the barometric altitude calibrator
// no dependencies; compiled first

package bac_pkg;

    localparam int FRAC_BITS = 24;
    localparam int NUM_W     = 44;

    typedef logic [30:0] t_root_tab [0:FRAC_BITS];

    typedef enum logic [1:0] {
        CAL_NONE         = 2'd0,
        CAL_APPLIED      = 2'd1,
        CAL_NO_SAMPLE    = 2'd2,
        CAL_OUT_OF_RANGE = 2'd3
    } t_cal_status;

    localparam logic [31:0] HPA_Q8       = 32'd25600;
    localparam logic [31:0] HEIGHT_SCALE = 32'd443300;
    localparam logic [24:0] P_LOW_Q8     = 25'd7680000;
    localparam logic [24:0] P_HIGH_Q8    = 25'd30720000;
    localparam logic [41:0] IMPL_LOW     = 42'd943718400;
    localparam logic [41:0] IMPL_HIGH    = 42'd1153433600;
    localparam logic [30:0] SEA_RESET    = 31'd1062469632;

    localparam logic signed [31:0] LOG_ZERO   = 32'shC000_0000;
    localparam logic signed [31:0] TWENTY_Q24 = 32'sd335544320;
    localparam logic signed [31:0] Y_MIN      = -32'sd536870912;
    localparam logic signed [31:0] Y_ALT_MAX  = 32'sd134217728;
    localparam logic signed [31:0] Y_CAL_MAX  = 32'sd671088640;

    localparam logic signed [43:0] MUL_ALT  = 44'sd1903;
    localparam logic signed [43:0] MUL_CAL  = 44'sd5255;
    localparam logic signed [39:0] MUL_STEP = 40'sd131;
    localparam logic [13:0]        DIV_ALT  = 14'd10000;
    localparam logic [13:0]        DIV_CAL  = 14'd1000;
    localparam logic signed [6:0]  OFF_ALT  = 7'sd0;
    localparam logic signed [6:0]  OFF_CAL  = -7'sd30;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // q1.30 factors 2^(2^-k); entry 0 is unity
    function automatic t_root_tab build_roots();
        t_root_tab   t;
        logic [63:0] prev;
        t[0] = 31'h4000_0000;
        prev = isqrt64(64'd1 << 61);
        t[1] = prev[30:0];
        for (int k = 2; k <= FRAC_BITS; k++) begin
            prev = isqrt64(prev << 30);
            t[k] = prev[30:0];
        end
        return t;
    endfunction

    localparam t_root_tab ROOT_TAB = build_roots();

endpackage

FILE: rtl/bac_if.sv
// valid/ready channel interfaces for input and result beats
// no dependencies

interface bac_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [24:0]        pressure_q8;
    logic signed [17:0] gps_alt_dm;
    logic               gps_valid;

    modport source (output valid, func, pressure_q8, gps_alt_dm, gps_valid, input ready);
    modport sink (input valid, func, pressure_q8, gps_alt_dm, gps_valid, output ready);
endinterface

interface bac_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] altitude_dm;
    logic               altitude_updated;
    logic [30:0]        sea_level_q20;
    logic [1:0]         cal_status;

    modport source (output valid, altitude_dm, altitude_updated, sea_level_q20, cal_status,
                    input ready);
    modport sink (input valid, altitude_dm, altitude_updated, sea_level_q20, cal_status,
                  output ready);
endinterface

FILE: rtl/bac_log2.sv
// serial log2 in signed q.24: one-bit normalising shift, then one squaring per cycle
// depends on bac_pkg

module bac_log2 import bac_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_x,
    output logic               o_done,
    output logic signed [31:0] o_log
);

    typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} t_state;

    t_state                r_state;
    logic                  r_done;
    logic signed [31:0]    r_log;
    logic [31:0]           r_w;
    logic [4:0]            r_n;
    logic [4:0]            r_cnt;
    logic [30:0]           r_m;
    logic [FRAC_BITS-1:0]  r_frac;
    logic [61:0]           sq;
    logic [31:0]           sq_t;

    assign sq   = 62'(r_m) * 62'(r_m);
    assign sq_t = sq[61:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == L_IDLE && i_start && i_x == '0) ||
                      (r_state == L_SQ && r_cnt == 5'(FRAC_BITS - 1));
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        if (i_x == '0) begin
                            r_log <= LOG_ZERO;
                        end else begin
                            r_w     <= i_x;
                            r_n     <= 5'd31;
                            r_state <= L_NORM;
                        end
                    end
                end
                L_NORM: begin
                    if (r_w[31]) begin
                        r_m     <= r_w[31:1];
                        r_cnt   <= '0;
                        r_frac  <= '0;
                        r_state <= L_SQ;
                    end else begin
                        r_w <= r_w << 1;
                        r_n <= r_n - 5'd1;
                    end
                end
                L_SQ: begin
                    r_m    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                    r_frac <= {r_frac[FRAC_BITS-2:0], sq_t[31]};
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'(FRAC_BITS - 1)) begin
                        r_log   <= {3'b000, r_n, r_frac[FRAC_BITS-2:0], sq_t[31]};
                        r_state <= L_IDLE;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_log  = r_log;

endmodule

FILE: rtl/bac_exp2.sv
// serial 2^y: one fraction bit per cycle scales the accumulator by a root table entry
// depends on bac_pkg

module bac_exp2 import bac_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_y,
    input  logic signed [6:0]  i_off,
    output logic               o_done,
    output logic [41:0]        o_val
);

    typedef enum logic [1:0] {E_IDLE, E_RUN, E_SHIFT} t_state;

    t_state               r_state;
    logic                 r_done;
    logic [41:0]          r_val;
    logic [30:0]          r_acc;
    logic [FRAC_BITS-1:0] r_f;
    logic [4:0]           r_k;
    logic signed [7:0]    r_s;
    logic [61:0]          prod;
    logic [7:0]           neg_s;

    assign prod  = 62'(r_acc) * 62'(ROOT_TAB[r_k]);
    assign neg_s = 8'(-r_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == E_SHIFT);
            unique case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_acc   <= ROOT_TAB[0];
                        r_f     <= i_y[FRAC_BITS-1:0];
                        r_k     <= 5'd1;
                        r_s     <= $signed(i_y[31:24]) + $signed({i_off[6], i_off});
                        r_state <= E_RUN;
                    end
                end
                E_RUN: begin
                    if (r_f[FRAC_BITS-1]) begin
                        r_acc <= prod[60:30];
                    end
                    r_f <= r_f << 1;
                    r_k <= r_k + 5'd1;
                    if (r_k == 5'(FRAC_BITS)) begin
                        r_state <= E_SHIFT;
                    end
                end
                E_SHIFT: begin
                    if (!r_s[7]) begin
                        r_val <= {11'b0, r_acc} << r_s[3:0];
                    end else begin
                        r_val <= {11'b0, r_acc} >> neg_s[5:0];
                    end
                    r_state <= E_IDLE;
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_val  = r_val;

endmodule

FILE: rtl/bac_cdiv.sv
// bit-serial restoring divide of a signed value by a small constant, truncating toward zero
// depends on bac_pkg

module bac_cdiv import bac_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [13:0]            i_den,
    output logic                   o_done,
    output logic signed [NUM_W-1:0] o_quo
);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} t_state;

    t_state            r_state;
    logic              r_done;
    logic [NUM_W-1:0]  r_quo;
    logic [NUM_W-1:0]  r_q;
    logic [13:0]       r_r;
    logic [13:0]       r_den;
    logic              r_neg;
    logic [5:0]        r_cnt;
    logic [14:0]       trial;
    logic              ge;
    logic [14:0]       diff;

    assign trial = {r_r, r_q[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == D_FIN);
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_num[NUM_W-1];
                        r_q     <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
                        r_r     <= '0;
                        r_den   <= i_den;
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_r   <= ge ? diff[13:0] : trial[13:0];
                    r_q   <= {r_q[NUM_W-2:0], ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(NUM_W - 1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    r_quo   <= r_neg ? -r_q : r_q;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quo  = $signed(r_quo);

endmodule

FILE: rtl/barometric_altitude_calibrator.sv
// barometric altitude with sea-level calibration; sequencer over serial log2, divide and exp2
// an out-of-band pressure or rejected gps beat goes straight to the output state; in-band
// pressure and gps calibration pass through the log2 unit (up to 17 normalising shifts and
// 24 squarings per operand), the 44-bit divider and 24 exp2 steps
// one beat in flight at a time; a stalled result holds the sequencer in its output state
// synchronous active-low reset: sea level 1013.25 hpa, altitude and stored pressure zero

module barometric_altitude_calibrator import bac_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bac_in_if.sink    i_in,
    bac_out_if.source o_out
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOG_GO, S_LOG_WAIT, S_SUM, S_MUL, S_DIV_GO, S_DIV_WAIT,
        S_EXP_GO, S_EXP_WAIT, S_ALT_MUL, S_ALT_FIN, S_CHECK, S_STEP, S_APPLY, S_OUT
    } t_state;

    t_state              r_state;
    logic                r_func;
    logic signed [17:0]  r_h;
    logic [24:0]         r_last_p;
    logic [30:0]         r_sea;
    logic signed [17:0]  r_alt;
    logic [1:0]          r_idx;
    logic signed [31:0]  r_lg [0:3];
    logic signed [33:0]  r_sum;
    logic signed [NUM_W-1:0] r_num;
    logic signed [31:0]  r_y;
    logic [41:0]         r_e;
    logic [58:0]         r_pa;
    logic signed [31:0]  r_d;
    logic signed [39:0]  r_sp;
    logic                r_upd;
    t_cal_status         r_status;
    logic                r_ov;
    logic signed [17:0]  r_oalt;
    logic                r_oupd;
    logic [30:0]         r_osea;
    t_cal_status         r_ostat;

    logic [31:0]             log_x;
    logic                    log_done;
    logic signed [31:0]      log_q;
    logic                    div_done;
    logic signed [NUM_W-1:0] div_q;
    logic                    exp_done;
    logic [41:0]             exp_v;
    logic [1:0]              last_idx;
    logic signed [31:0]      h_ext;
    logic signed [NUM_W-1:0] sum_ext;
    logic signed [45:0]      y_cal;
    logic signed [31:0]      y_next;
    logic [59:0]             pa_rnd;
    logic signed [31:0]      alt_raw;
    logic signed [17:0]      alt_sat;
    logic [39:0]             sp_mag;
    logic signed [31:0]      step;
    logic [31:0]             sea_sum;
    logic                    in_band;

    assign h_ext    = {{14{r_h[17]}}, r_h};
    assign last_idx = r_func ? 2'd3 : 2'd2;
    assign in_band  = (i_in.pressure_q8 > P_LOW_Q8) && (i_in.pressure_q8 < P_HIGH_Q8);

    always_comb begin
        case ({r_func, r_idx})
            3'b000:  log_x = {7'b0, r_last_p};
            3'b001:  log_x = HPA_Q8;
            3'b010:  log_x = {1'b0, r_sea};
            3'b100:  log_x = HEIGHT_SCALE - h_ext;
            3'b101:  log_x = HEIGHT_SCALE;
            3'b110:  log_x = {7'b0, r_last_p};
            default: log_x = HPA_Q8;
        endcase
    end

    always_comb begin
        sum_ext = NUM_W'(r_sum);
        y_cal   = 46'(r_lg[2]) - 46'(r_lg[3]) + 46'(TWENTY_Q24) - 46'(div_q);
        if (r_func) begin
            if (y_cal < 46'(Y_MIN)) begin
                y_next = Y_MIN;
            end else if (y_cal > 46'(Y_CAL_MAX)) begin
                y_next = Y_CAL_MAX;
            end else begin
                y_next = y_cal[31:0];
            end
        end else begin
            if (div_q < NUM_W'(Y_MIN)) begin
                y_next = Y_MIN;
            end else if (div_q > NUM_W'(Y_ALT_MAX)) begin
                y_next = Y_ALT_MAX;
            end else begin
                y_next = div_q[31:0];
            end
        end
        pa_rnd  = 60'(r_pa) + 60'h000_0000_2000_0000;
        alt_raw = $signed(HEIGHT_SCALE) - $signed({2'b00, pa_rnd[59:30]});
        if (alt_raw > 32'sd131071) begin
            alt_sat = 18'sd131071;
        end else if (alt_raw < -32'sd131072) begin
            alt_sat = -18'sd131072;
        end else begin
            alt_sat = alt_raw[17:0];
        end
        sp_mag = r_sp[39] ? 40'(-r_sp) : 40'(r_sp);
        step   = r_sp[39] ? -$signed({8'b0, sp_mag[39:16]}) : $signed({8'b0, sp_mag[39:16]});
        sea_sum = 32'($signed({1'b0, r_sea}) + step);
    end

    bac_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LOG_GO),
        .i_x     (log_x),
        .o_done  (log_done),
        .o_log   (log_q)
    );

    bac_cdiv u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV_GO),
        .i_num   (r_num),
        .i_den   (r_func ? DIV_CAL : DIV_ALT),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    bac_exp2 u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_EXP_GO),
        .i_y     (r_y),
        .i_off   (r_func ? OFF_CAL : OFF_ALT),
        .o_done  (exp_done),
        .o_val   (exp_v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ov     <= 1'b0;
            r_last_p <= '0;
            r_sea    <= SEA_RESET;
            r_alt    <= '0;
        end else begin
            if (r_state == S_OUT && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_func   <= i_in.func;
                        r_h      <= i_in.gps_alt_dm;
                        r_idx    <= '0;
                        r_upd    <= !i_in.func && in_band;
                        r_status <= (i_in.func && (!i_in.gps_valid || r_last_p < P_LOW_Q8)) ?
                                    CAL_NO_SAMPLE : CAL_NONE;
                        if (!i_in.func) begin
                            r_last_p <= i_in.pressure_q8;
                            r_state  <= in_band ? S_LOG_GO : S_OUT;
                        end else if (!i_in.gps_valid || r_last_p < P_LOW_Q8) begin
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_LOG_GO;
                        end
                    end
                end
                S_LOG_GO: r_state <= S_LOG_WAIT;
                S_LOG_WAIT: begin
                    if (log_done) begin
                        r_lg[r_idx] <= log_q;
                        if (r_idx == last_idx) begin
                            r_state <= S_SUM;
                        end else begin
                            r_idx   <= r_idx + 2'd1;
                            r_state <= S_LOG_GO;
                        end
                    end
                end
                S_SUM: begin
                    if (r_func) begin
                        r_sum <= 34'(r_lg[0]) - 34'(r_lg[1]);
                    end else begin
                        r_sum <= 34'(r_lg[0]) + 34'(TWENTY_Q24) - 34'(r_lg[1]) - 34'(r_lg[2]);
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_num   <= sum_ext * (r_func ? MUL_CAL : MUL_ALT);
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_y     <= y_next;
                        r_state <= S_EXP_GO;
                    end
                end
                S_EXP_GO: r_state <= S_EXP_WAIT;
                S_EXP_WAIT: begin
                    if (exp_done) begin
                        r_e     <= exp_v;
                        r_state <= r_func ? S_CHECK : S_ALT_MUL;
                    end
                end
                S_ALT_MUL: begin
                    r_pa    <= 59'(r_e[39:0]) * 59'(HEIGHT_SCALE[18:0]);
                    r_state <= S_ALT_FIN;
                end
                S_ALT_FIN: begin
                    r_alt   <= alt_sat;
                    r_state <= S_OUT;
                end
                S_CHECK: begin
                    if (r_e < IMPL_LOW || r_e > IMPL_HIGH) begin
                        r_status <= CAL_OUT_OF_RANGE;
                        r_state  <= S_OUT;
                    end else begin
                        r_d     <= $signed({1'b0, r_e[30:0]}) - $signed({1'b0, r_sea});
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    r_sp    <= 40'(r_d) * MUL_STEP;
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_sea    <= sea_sum[30:0];
                    r_status <= CAL_APPLIED;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || o_out.ready) begin
                        r_oalt  <= r_alt;
                        r_oupd  <= r_upd;
                        r_osea  <= r_sea;
                        r_ostat <= r_status;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = r_ov;
    assign o_out.altitude_dm      = r_oalt;
    assign o_out.altitude_updated = r_oupd;
    assign o_out.sea_level_q20    = r_osea;
    assign o_out.cal_status       = r_ostat;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("accepted beat left the sequencer idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_sea != $past(r_sea))) |-> ($past(r_state) == S_APPLY))
        else $error("sea level changed outside the calibration step");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.altitude_updated) |-> (o_out.cal_status == CAL_NONE))
        else $error("altitude update reported with a calibration status");

endmodule
